// ===== rtl/core/mbsf_pkg.sv =====
// Package for the MIDI byte stream framer: widths, MIDI codes, controller
// states, command and status structs, and the message length decoder.
// No dependencies.
package mbsf_pkg;

  localparam int BYTE_W        = 8;
  localparam int LIMIT_W       = 7;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic [BYTE_W-1:0]  SYSEX_START = 8'hF0;
  localparam logic [BYTE_W-1:0]  SYSEX_END   = 8'hF7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd3;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;   // an input byte is taken this cycle
    logic load;   // move the buffer read data into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;      // the byte at the input completes a message
    logic last;      // the read pointer is on the final byte of the message
    logic out_free;  // the output register can take a byte this cycle
  } ctrl_sts_t;

  // Number of bytes that completes a message opened by this status byte.
  // Zero means the message never completes on its own.
  function automatic logic [1:0] msg_length(input logic [BYTE_W-1:0] status);
    logic [1:0] len;
    len = 2'd0;
    if (!status[7]) begin
      len = 2'd0;
    end else if (status[7:4] == 4'hC || status[7:4] == 4'hD) begin
      len = 2'd2;
    end else if (status[7:4] != 4'hF) begin
      len = 2'd3;
    end else begin
      unique case (status) inside
        8'hF1, 8'hF3: len = 2'd2;
        8'hF2: len = 2'd3;
        8'hF6, 8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF: len = 2'd1;
        default: len = 2'd0;
      endcase
    end
    return len;
  endfunction

endpackage

// ===== rtl/core/mbsf_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module mbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mbsf_ctrl.sv =====
// Controller for the MIDI framer: takes bytes and sequences the read-out
// of a completed message. Depends on mbsf_pkg.
module mbsf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output mbsf_pkg::ctrl_cmd_t cmd,
  input  mbsf_pkg::ctrl_sts_t sts
);
  import mbsf_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.step   = 1'b0;
    cmd.load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.step = in_valid;
        if (in_valid && sts.done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = sts.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mbsf_dp.sv =====
// Datapath for the MIDI framer: limit register, framing state, message
// buffer, read pointer and output register. Depends on mbsf_pkg, mbsf_ram.
module mbsf_dp #(
  parameter int BUFFER_DEPTH = mbsf_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [mbsf_pkg::LIMIT_W-1:0] cfg_data,
  input  logic [mbsf_pkg::BYTE_W-1:0]  rx_byte,
  input  mbsf_pkg::ctrl_cmd_t          cmd,
  output mbsf_pkg::ctrl_sts_t          sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [mbsf_pkg::BYTE_W-1:0]  msg_byte,
  output logic                         is_exclusive,
  output logic                         last_byte
);
  import mbsf_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

  logic [LIMIT_W-1:0] limit;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;
  logic               in_excl;
  logic               in_excl_next;
  logic               in_msg;
  logic               in_msg_next;
  logic [1:0]         status_len;
  logic [FILL_W-1:0]  emit_n;
  logic               emit_excl;
  logic [ADDR_W-1:0]  rd_ptr;

  logic [FILL_W-1:0]  lim_eff;
  logic [FILL_W-1:0]  fill_base;
  logic [FILL_W-1:0]  fill_inc;
  logic [1:0]         cur_len;
  logic               is_status;
  logic               wr_en;
  logic               done;
  logic [BYTE_W-1:0]  rd_data;

  // Effective limit: zero acts as the reset value, large values clamp to the depth.
  always_comb begin
    if (limit == '0) begin
      lim_eff = FILL_W'(LIMIT_RESET);
    end else if (limit > LIMIT_W'(BUFFER_DEPTH)) begin
      lim_eff = FILL_W'(BUFFER_DEPTH);
    end else begin
      lim_eff = FILL_W'(limit);
    end
  end

  // Framing decision for the byte at the input.
  always_comb begin
    is_status    = rx_byte[7];
    fill_base    = (!in_excl && is_status) ? '0 : fill;
    fill_inc     = fill_base + 1'b1;
    cur_len      = is_status ? msg_length(rx_byte) : status_len;
    fill_next    = fill;
    in_excl_next = in_excl;
    in_msg_next  = in_msg;
    wr_en        = 1'b0;
    done         = 1'b0;
    if (in_excl) begin
      // Exclusive capture stores every byte, up to the limit, until the end code.
      if (fill >= lim_eff) begin
        in_excl_next = 1'b0;
        fill_next    = '0;
      end else begin
        wr_en = 1'b1;
        if (rx_byte == SYSEX_END) begin
          in_excl_next = 1'b0;
          done         = 1'b1;
          fill_next    = '0;
        end else if (fill_inc >= lim_eff) begin
          in_excl_next = 1'b0;
          fill_next    = '0;
        end else begin
          fill_next = fill_inc;
        end
      end
    end else if (is_status && rx_byte == SYSEX_START) begin
      in_excl_next = 1'b1;
      in_msg_next  = 1'b0;
      fill_next    = '0;
    end else if (is_status || in_msg) begin
      // Ordinary message: completion is tested before the limit.
      if (fill_base >= lim_eff) begin
        in_msg_next = 1'b0;
        fill_next   = '0;
      end else begin
        wr_en = 1'b1;
        if (cur_len != 2'd0 && fill_inc == FILL_W'(cur_len)) begin
          in_msg_next = 1'b0;
          done        = 1'b1;
          fill_next   = '0;
        end else if (fill_inc >= lim_eff) begin
          in_msg_next = 1'b0;
          fill_next   = '0;
        end else begin
          in_msg_next = 1'b1;
          fill_next   = fill_inc;
        end
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // Framing state, updated once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      in_excl <= 1'b0;
      in_msg  <= 1'b0;
    end else if (cmd.step) begin
      fill    <= fill_next;
      in_excl <= in_excl_next;
      in_msg  <= in_msg_next;
    end
  end

  // Message description and read pointer for the read-out.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_len <= 2'd0;
      emit_n     <= '0;
      emit_excl  <= 1'b0;
      rd_ptr     <= '0;
    end else if (cmd.step) begin
      if (!in_excl && is_status) begin
        status_len <= cur_len;
      end
      if (done) begin
        emit_n    <= fill_inc;
        emit_excl <= in_excl;
        rd_ptr    <= '0;
      end
    end else if (cmd.load) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // Message buffer.
  mbsf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.step && wr_en),
    .waddr (fill_base[ADDR_W-1:0]),
    .wdata (rx_byte),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  // Output register; it holds its byte until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      msg_byte     <= rd_data;
      is_exclusive <= emit_excl;
      last_byte    <= sts.last;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.done     = done;
    sts.last     = (FILL_W'(rd_ptr) == emit_n - 1'b1);
    sts.out_free = !out_valid || out_ready;
  end

endmodule

// ===== rtl/core/midi_byte_stream_framer_top.sv =====
// Top level of the MIDI byte stream framer: controller plus datapath.
// Depends on mbsf_pkg, mbsf_ctrl, mbsf_dp (and mbsf_ram below it).
//
//   Channel   Signals                                        Direction
//   input     in_valid, in_ready, rx_byte                    in
//   output    out_valid, out_ready, msg_byte,                out
//             is_exclusive, last_byte
//   config    cfg_valid, cfg_ready, cfg_data (buffer limit)  in
//
// A byte that completes no message leaves the controller in ST_IDLE, so
// bytes may arrive back to back. A completed message is read out of the
// buffer RAM byte by byte via a registered read (ST_READ) and an output
// load (ST_LOAD); input waits for the last load, output stalls included.
// Synchronous reset clears the framing state and sets the limit to 3.
// The output register holds a byte while out_ready is low.
module midi_byte_stream_framer_top #(
  parameter int BUFFER_DEPTH = mbsf_pkg::DEFAULT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] msg_byte,
  output logic       is_exclusive,
  output logic       last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);
  import mbsf_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  mbsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mbsf_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .msg_byte     (msg_byte),
    .is_exclusive (is_exclusive),
    .last_byte    (last_byte)
  );

  // A byte is never loaded over one that is still waiting at the output.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("output register overwritten while stalled");

  // Completing a message stops input until the read-out is over.
  a_done_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.done) |=> !in_ready)
    else $error("input taken while a message is pending read-out");

  // Loading the final byte returns the block to taking input.
  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && sts.last) |=> in_ready)
    else $error("input not resumed after the last byte");

endmodule

// ===== test/midi_frame_checker.sv =====
// Checker for the MIDI byte stream framer: follows the input and config
// transactions, predicts the framed output bytes and compares them with the
// output channel. Depends on mbsf_pkg.
module midi_frame_checker #(
  parameter int DEPTH = mbsf_pkg::DEFAULT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] msg_byte,
  input  logic       is_exclusive,
  input  logic       last_byte,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         pending_count
);
  import mbsf_pkg::*;

  // System common and real-time status bytes with a fixed length.
  localparam logic [7:0] MTC_QUARTER  = 8'hF1;
  localparam logic [7:0] SONG_POS     = 8'hF2;
  localparam logic [7:0] SONG_SELECT  = 8'hF3;
  localparam logic [7:0] TUNE_REQUEST = 8'hF6;
  localparam logic [7:0] TIMING_CLOCK = 8'hF8;
  localparam logic [7:0] SEQ_START    = 8'hFA;
  localparam logic [7:0] SEQ_CONTINUE = 8'hFB;
  localparam logic [7:0] SEQ_STOP     = 8'hFC;
  localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
  localparam logic [7:0] SYSTEM_RESET = 8'hFF;

  typedef struct packed {
    logic [7:0] data;
    logic       excl;
    logic       last;
  } framed_byte_t;

  framed_byte_t       framed_fifo[$];
  framed_byte_t       want;
  logic [7:0]         held_bytes[DEPTH];
  int                 held_count;
  logic               in_sysex;
  logic               in_msg;
  logic [LIMIT_W-1:0] limit_reg;

  // Bytes that complete a message opened by this status; zero means never.
  function automatic int status_length(input logic [7:0] status);
    int len;
    len = 0;
    if (status >= 8'h80 && status < 8'hF0) begin
      len = (status[7:5] == 3'b110) ? 2 : 3;
    end else begin
      case (status)
        MTC_QUARTER, SONG_SELECT: len = 2;
        SONG_POS: len = 3;
        TUNE_REQUEST, TIMING_CLOCK, SEQ_START, SEQ_CONTINUE, SEQ_STOP,
        ACTIVE_SENSE, SYSTEM_RESET: len = 1;
        default: len = 0;
      endcase
    end
    return len;
  endfunction

  function void note_failure(input string what);
    if (fail_count < 10) begin
      $display("mismatch: %s", what);
    end
    fail_count++;
  endfunction

  // Queue the held message as framed output bytes and empty the buffer.
  function void release_message(input logic excl);
    framed_byte_t entry;
    for (int k = 0; k < held_count; k++) begin
      entry = '{data: held_bytes[k], excl: excl, last: (k == held_count - 1)};
      framed_fifo.insert(framed_fifo.size(), entry);
    end
    held_count = 0;
  endfunction

  // Advance the framing state by one received byte.
  task automatic frame_byte(input logic [7:0] b);
    int lim;
    int need;
    lim = (limit_reg == 0) ? 3 : ((limit_reg > DEPTH) ? DEPTH : int'(limit_reg));
    if (in_sysex) begin
      // Exclusive capture stores every byte up to the limit; the end byte closes the message.
      if (held_count >= lim) begin
        in_sysex   = 1'b0;
        held_count = 0;
        return;
      end
      held_bytes[held_count] = b;
      held_count++;
      if (b == SYSEX_END) begin
        in_sysex = 1'b0;
        release_message(1'b1);
      end else if (held_count >= lim) begin
        in_sysex   = 1'b0;
        held_count = 0;
      end
      return;
    end
    if (b[7]) begin
      held_count = 0;
      if (b == SYSEX_START) begin
        in_sysex = 1'b1;
        in_msg   = 1'b0;
        return;
      end
      in_msg = 1'b1;
    end
    if (!in_msg) begin
      return;
    end
    if (held_count >= lim) begin
      in_msg     = 1'b0;
      held_count = 0;
      return;
    end
    held_bytes[held_count] = b;
    held_count++;
    // Completion is tested before the limit.
    need = status_length(held_bytes[0]);
    if (need != 0 && held_count == need) begin
      in_msg = 1'b0;
      release_message(1'b0);
    end else if (held_count >= lim) begin
      in_msg     = 1'b0;
      held_count = 0;
    end
  endtask

  // Sample every channel at the rising edge and check each output transaction.
  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      in_sysex   = 1'b0;
      in_msg     = 1'b0;
      limit_reg  = LIMIT_RESET;
      framed_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        frame_byte(rx_byte);
      end
      if (out_valid && out_ready) begin
        if (framed_fifo.size() == 0) begin
          note_failure($sformatf("unexpected byte %02h excl %0b last %0b",
                                 msg_byte, is_exclusive, last_byte));
        end else begin
          want = framed_fifo.pop_front();
          if (want.data !== msg_byte || want.excl !== is_exclusive ||
              want.last !== last_byte) begin
            note_failure($sformatf(
              "expected byte %02h excl %0b last %0b, got %02h excl %0b last %0b",
              want.data, want.excl, want.last, msg_byte, is_exclusive, last_byte));
          end
        end
      end
    end
    pending_count = framed_fifo.size();
  end

endmodule

// ===== test/tb_midi_byte_stream_framer_top.sv =====
// Testbench top for the MIDI byte stream framer: drives directed and random
// byte streams and buffer limits, and reports the verdict of the checker.
// Depends on mbsf_pkg, midi_byte_stream_framer_top and midi_frame_checker.
module tb_midi_byte_stream_framer_top;
  import mbsf_pkg::*;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] msg_byte;
  logic       is_exclusive;
  logic       last_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data  = 7'd0;

  int fail_count;
  int pending_count;
  int bytes_sent    = 0;
  int cur_limit     = 3;
  int stall_left    = 0;
  bit in_gaps_on    = 1'b0;
  bit out_stalls_on = 1'b0;

  midi_byte_stream_framer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .msg_byte     (msg_byte),
    .is_exclusive (is_exclusive),
    .last_byte    (last_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  midi_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .msg_byte      (msg_byte),
    .is_exclusive  (is_exclusive),
    .last_byte     (last_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("midi_byte_stream_framer_top test failed");
    $finish;
  end

  // Idle length: mostly none, sometimes short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 8);
  endfunction

  // Output back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_stalls_on) begin
        stall_left <= pick_gap();
      end
    end
  end

  // Offer one byte and wait until the input transaction completes.
  task automatic send_midi_byte(input logic [7:0] b);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop offering input and let every predicted byte come out.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write the buffer limit; the caller makes sure the block is idle.
  task automatic set_buffer_limit(input logic [6:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_limit = (value == 0) ? 3 : ((value > 64) ? 64 : int'(value));
  endtask

  initial begin
    int         roll;
    int         data_count;
    int         next_phase;
    logic [7:0] status;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: stray data, each message length, exclusive capture holding a
    // status byte, and an exclusive message cut off by the reset limit.
    send_midi_byte(8'h00);
    send_midi_byte(8'h90); send_midi_byte(8'h3C); send_midi_byte(8'h7F);
    send_midi_byte(8'hC5); send_midi_byte(8'h10);
    send_midi_byte(8'hF8);
    send_midi_byte(SYSEX_START); send_midi_byte(8'h90); send_midi_byte(SYSEX_END);
    send_midi_byte(8'hF1); send_midi_byte(8'h7F);
    send_midi_byte(8'hF2); send_midi_byte(8'h00); send_midi_byte(8'h7F);
    send_midi_byte(SYSEX_START); send_midi_byte(8'h11); send_midi_byte(8'h22);
    send_midi_byte(8'h33);
    send_midi_byte(8'hFF);
    wait_quiet();

    // Limit of one: an open-ended status drops, a one-byte message still goes.
    set_buffer_limit(7'd1);
    send_midi_byte(8'hF4); send_midi_byte(8'hF6); send_midi_byte(8'h90);
    wait_quiet();

    // Zero acts as three; then the limit drops under a half-built message.
    set_buffer_limit(7'd0);
    send_midi_byte(8'hE0); send_midi_byte(8'h01);
    wait_quiet();
    set_buffer_limit(7'd1);
    send_midi_byte(8'h02);
    wait_quiet();
    set_buffer_limit(7'd127);

    // Random phases, each with its own limit and idling mix.
    next_phase = bytes_sent + 40;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    while (bytes_sent < 460) begin
      if (bytes_sent >= next_phase) begin
        wait_quiet();
        roll = $urandom_range(99);
        if (roll < 10) begin
          set_buffer_limit(7'd0);
        end else if (roll < 20) begin
          set_buffer_limit(7'd1);
        end else if (roll < 28) begin
          set_buffer_limit(7'd64);
        end else if (roll < 34) begin
          set_buffer_limit(7'd127);
        end else if (roll < 44) begin
          set_buffer_limit(7'($urandom_range(127)));
        end else begin
          set_buffer_limit(7'($urandom_range(16, 2)));
        end
        in_gaps_on    = ($urandom_range(99) < 75);
        out_stalls_on = ($urandom_range(99) < 75);
        next_phase    = bytes_sent + $urandom_range(60, 25);
      end
      roll = $urandom_range(99);
      if (roll < 40) begin
        // Channel voice message, now and then with a wrong data count.
        status = 8'($urandom_range(8'hEF, 8'h80));
        data_count = (status[7:5] == 3'b110) ? 1 : 2;
        if ($urandom_range(9) == 0) begin
          data_count = $urandom_range(3);
        end
        send_midi_byte(status);
        repeat (data_count) send_midi_byte(8'($urandom_range(127)));
      end else if (roll < 60) begin
        // Exclusive message, mostly short enough and properly ended.
        if ($urandom_range(3) == 0) begin
          data_count = $urandom_range(cur_limit + 1);
        end else begin
          data_count = $urandom_range(cur_limit - 1);
        end
        send_midi_byte(SYSEX_START);
        repeat (data_count) begin
          send_midi_byte(8'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                     : $urandom_range(127)));
        end
        if ($urandom_range(9) != 0) begin
          send_midi_byte(SYSEX_END);
        end
      end else if (roll < 75) begin
        // System common or real-time status with a few data bytes.
        send_midi_byte(8'($urandom_range(8'hFF, 8'hF1)));
        repeat ($urandom_range(2)) send_midi_byte(8'($urandom_range(127)));
      end else if (roll < 88) begin
        send_midi_byte(8'($urandom_range(255)));
      end else begin
        send_midi_byte(8'($urandom_range(127)));
      end
    end

    wait_quiet();
    if (fail_count == 0 && pending_count == 0) begin
      $display("midi_byte_stream_framer_top test passed");
    end else begin
      $display("midi_byte_stream_framer_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mbsf_pkg.sv
rtl/core/mbsf_ram.sv
rtl/core/mbsf_ctrl.sv
rtl/core/mbsf_dp.sv
rtl/core/midi_byte_stream_framer_top.sv
test/midi_frame_checker.sv
test/tb_midi_byte_stream_framer_top.sv
